// File: rtl/ppt_pkg.sv
package ppt_pkg;

  localparam int COEFF_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_INVERT = 2'd1;
  localparam logic [1:0] OP_XFORM  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_SINGULAR = 2'd1;
  localparam logic [1:0] STAT_SAT      = 2'd2;

  localparam logic [3:0] NUM_COEFF = 4'd9;
  localparam logic [3:0] SLOT_DEN  = 4'd9;

  localparam logic [4:0] INV_LAST_STEP = 5'd20;
  localparam logic [4:0] XF_LAST_STEP  = 5'd8;
  localparam logic [3:0] INV_LAST_DIV  = 4'd8;
  localparam logic [3:0] XF_LAST_DIV   = 4'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPA,
    ST_OPB,
    ST_MULW,
    ST_CHECK,
    ST_DIVS,
    ST_DIVW,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    B_COEF,
    B_SLOT,
    B_X,
    B_Y,
    B_ONE
  } bsel_t;

  typedef struct packed {
    logic [3:0] a_idx;
    bsel_t      b_sel;
    logic [3:0] b_idx;
    logic       sub;
    logic       first;
    logic       last;
    logic [3:0] dst;
  } step_t;

  function automatic step_t mk(input logic [3:0] a, input bsel_t bs, input logic [3:0] b,
                               input logic sub, input logic first, input logic last,
                               input logic [3:0] dst);
    step_t s;
    s.a_idx = a;
    s.b_sel = bs;
    s.b_idx = b;
    s.sub   = sub;
    s.first = first;
    s.last  = last;
    s.dst   = dst;
    return s;
  endfunction

  // cofactor products p*q - r*s, then det = m0*adj0 + m1*adj3 + m2*adj6
  function automatic step_t inv_step(input logic [4:0] n);
    step_t s;
    case (n)
      5'd0:  s = mk(4'd4, B_COEF, 4'd8, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd1:  s = mk(4'd5, B_COEF, 4'd7, 1'b1, 1'b0, 1'b1, 4'd0);
      5'd2:  s = mk(4'd2, B_COEF, 4'd7, 1'b0, 1'b1, 1'b0, 4'd1);
      5'd3:  s = mk(4'd1, B_COEF, 4'd8, 1'b1, 1'b0, 1'b1, 4'd1);
      5'd4:  s = mk(4'd1, B_COEF, 4'd5, 1'b0, 1'b1, 1'b0, 4'd2);
      5'd5:  s = mk(4'd2, B_COEF, 4'd4, 1'b1, 1'b0, 1'b1, 4'd2);
      5'd6:  s = mk(4'd5, B_COEF, 4'd6, 1'b0, 1'b1, 1'b0, 4'd3);
      5'd7:  s = mk(4'd3, B_COEF, 4'd8, 1'b1, 1'b0, 1'b1, 4'd3);
      5'd8:  s = mk(4'd0, B_COEF, 4'd8, 1'b0, 1'b1, 1'b0, 4'd4);
      5'd9:  s = mk(4'd2, B_COEF, 4'd6, 1'b1, 1'b0, 1'b1, 4'd4);
      5'd10: s = mk(4'd2, B_COEF, 4'd3, 1'b0, 1'b1, 1'b0, 4'd5);
      5'd11: s = mk(4'd0, B_COEF, 4'd5, 1'b1, 1'b0, 1'b1, 4'd5);
      5'd12: s = mk(4'd3, B_COEF, 4'd7, 1'b0, 1'b1, 1'b0, 4'd6);
      5'd13: s = mk(4'd4, B_COEF, 4'd6, 1'b1, 1'b0, 1'b1, 4'd6);
      5'd14: s = mk(4'd1, B_COEF, 4'd6, 1'b0, 1'b1, 1'b0, 4'd7);
      5'd15: s = mk(4'd0, B_COEF, 4'd7, 1'b1, 1'b0, 1'b1, 4'd7);
      5'd16: s = mk(4'd0, B_COEF, 4'd4, 1'b0, 1'b1, 1'b0, 4'd8);
      5'd17: s = mk(4'd1, B_COEF, 4'd3, 1'b1, 1'b0, 1'b1, 4'd8);
      5'd18: s = mk(4'd0, B_SLOT, 4'd0, 1'b0, 1'b1, 1'b0, SLOT_DEN);
      5'd19: s = mk(4'd1, B_SLOT, 4'd3, 1'b0, 1'b0, 1'b0, SLOT_DEN);
      5'd20: s = mk(4'd2, B_SLOT, 4'd6, 1'b0, 1'b0, 1'b1, SLOT_DEN);
      default: s = mk(4'd0, B_COEF, 4'd0, 1'b0, 1'b1, 1'b1, SLOT_DEN);
    endcase
    return s;
  endfunction

  // w into the denominator slot, x numerator into slot 0, y numerator into slot 1
  function automatic step_t xf_step(input logic [4:0] n);
    step_t s;
    case (n)
      5'd0: s = mk(4'd6, B_X,   4'd0, 1'b0, 1'b1, 1'b0, SLOT_DEN);
      5'd1: s = mk(4'd7, B_Y,   4'd0, 1'b0, 1'b0, 1'b0, SLOT_DEN);
      5'd2: s = mk(4'd8, B_ONE, 4'd0, 1'b0, 1'b0, 1'b1, SLOT_DEN);
      5'd3: s = mk(4'd0, B_X,   4'd0, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd4: s = mk(4'd1, B_Y,   4'd0, 1'b0, 1'b0, 1'b0, 4'd0);
      5'd5: s = mk(4'd2, B_ONE, 4'd0, 1'b0, 1'b0, 1'b1, 4'd0);
      5'd6: s = mk(4'd3, B_X,   4'd0, 1'b0, 1'b1, 1'b0, 4'd1);
      5'd7: s = mk(4'd4, B_Y,   4'd0, 1'b0, 1'b0, 1'b0, 4'd1);
      5'd8: s = mk(4'd5, B_ONE, 4'd0, 1'b0, 1'b0, 1'b1, 4'd1);
      default: s = mk(4'd0, B_X, 4'd0, 1'b0, 1'b1, 1'b1, 4'd0);
    endcase
    return s;
  endfunction

endpackage

// File: rtl/ppt_mul.sv
module ppt_mul #(
  parameter int AW = 32,
  parameter int W  = 148
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [AW-1:0] a,
  input  logic signed [W-1:0]  b,
  output logic                done,
  output logic signed [W-1:0]  prod
);
  localparam int CW_ = (AW > 1) ? $clog2(AW) : 1;
  localparam logic [CW_-1:0] LAST = CW_'(AW - 1);

  logic [AW-1:0]       ma_r;
  logic [W-1:0]        mb_r;
  logic [W-1:0]        prod_r;
  logic [CW_-1:0]      cnt_r;
  logic                busy_r;
  logic                done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        ma_r   <= a[AW-1] ? (AW'(0) - a) : a;
        mb_r   <= a[AW-1] ? (W'(0) - b) : b;
        prod_r <= '0;
      end else if (busy_r) begin
        if (ma_r[0]) prod_r <= prod_r + mb_r;
        ma_r <= ma_r >> 1;
        mb_r <= mb_r << 1;
        cnt_r <= cnt_r + CW_'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("multiply started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == LAST) |=> (done_r && !busy_r))
    else $error("multiply did not finish");
  a_done_one: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("done while busy");
endmodule

// File: rtl/ppt_div.sv
module ppt_div #(
  parameter int W = 148
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic               done,
  output logic signed [W-1:0] quo
);
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

  logic [W-1:0]     a_r;
  logic [W-1:0]     b_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic             busy_r;
  logic             fix_r;
  logic             done_r;
  logic [W:0]       rem_sh;
  logic [W+1:0]     diff;

  assign rem_sh = {rem_r, a_r[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fix_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= num[W-1] ? (W'(0) - num) : num;
        b_r    <= den[W-1] ? (W'(0) - den) : den;
        neg_r  <= num[W-1] ^ den[W-1];
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= diff[W+1] ? rem_sh[W-1:0] : diff[W-1:0];
        a_r   <= {a_r[W-2:0], ~diff[W+1]};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        q_r    <= neg_r ? (W'(0) - a_r) : a_r;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r && !fix_r)
    else $error("divide started while busy");
  a_fix_done: assert property (@(posedge clk) disable iff (!rst_n) fix_r |=> done_r)
    else $error("sign fix not followed by done");
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n) !(busy_r && fix_r))
    else $error("iterate and fix together");
endmodule

// File: rtl/projective_point_transform_unit.sv
// channel | signals                                            | accepted when
// in      | in_opcode in_coeff_index in_coeff_value in_point_x/y | in_valid && in_ready
// out     | out_x out_y out_status                             | out_valid && out_ready
// Write and no-op items go straight to the output stage. Transform: 9 shift-add multiplies
// and 2 restoring divides of W-bit values, W = 3*COEFF_WIDTH+2*FRAC_BITS+4.
// Invert: 21 multiplies and 9 divides on the same shared units.
// Synchronous active-low reset loads the identity matrix and empties the output register.
// One item at a time; a waiting result holds the block before it returns to idle.
module projective_point_transform_unit #(
  parameter int COEFF_WIDTH = ppt_pkg::COEFF_WIDTH_DEF,
  parameter int FRAC_BITS   = ppt_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_coeff_index,
  input  logic signed [31:0] in_coeff_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [1:0]         out_status
);
  import ppt_pkg::*;

  localparam int CW = COEFF_WIDTH;
  localparam int W  = 3 * COEFF_WIDTH + 2 * FRAC_BITS + 4;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE_C =
    (FRAC_BITS < COEFF_WIDTH - 1) ? (CW'(1) << FRAC_BITS) : C_MAX;
  localparam logic signed [31:0] P_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] P_MIN = 32'sh80000000;

  state_t state_r, state_nxt;

  logic signed [CW-1:0] mat_r [0:8];
  logic signed [W-1:0]  slot_r [0:9];
  logic signed [W-1:0]  acc_r;
  logic signed [CW-1:0] opa_r;
  logic [1:0]           op_r;
  logic signed [31:0]   px_r, py_r;
  logic [4:0]           step_r;
  logic [3:0]           k_r;
  logic                 sat_r;
  logic signed [31:0]   rx_r, ry_r;
  logic [1:0]           rstat_r;
  logic                 out_valid_r;
  logic signed [31:0]   out_x_r, out_y_r;
  logic [1:0]           out_status_r;

  step_t               st;
  logic                is_inv;
  logic                accept;
  logic                mul_start, div_start, out_load;
  logic                mul_done, div_done;
  logic signed [W-1:0] prod, quo;
  logic signed [W-1:0] b_opnd, acc_base, acc_nxt;
  logic [3:0]          slot_idx;
  logic signed [W-1:0] slot_rd, den, dividend;
  logic                den_zero;
  logic signed [CW-1:0] mat_rd;
  logic signed [W-1:0]  cv_w;
  logic signed [CW-1:0] cv_sat, q_cw;
  logic                 q_cw_sat;
  logic signed [31:0]   q_32;
  logic                 q_32_sat;

  assign is_inv = (op_r == OP_INVERT);
  assign st     = is_inv ? inv_step(step_r) : xf_step(step_r);
  assign accept = in_valid && in_ready;

  always_comb begin
    mat_rd = mat_r[0];
    if (state_r == ST_OPA) begin
      if (st.a_idx < NUM_COEFF) mat_rd = mat_r[st.a_idx];
    end else begin
      if (st.b_idx < NUM_COEFF) mat_rd = mat_r[st.b_idx];
    end
  end

  assign slot_idx = (state_r == ST_DIVS) ? k_r : st.b_idx;
  assign slot_rd  = slot_r[slot_idx];
  assign den      = slot_r[SLOT_DEN];
  assign den_zero = (den == '0);
  assign dividend = is_inv ? (slot_rd <<< (2 * FRAC_BITS)) : (slot_rd <<< FRAC_BITS);

  always_comb begin
    case (st.b_sel)
      B_COEF:  b_opnd = {{(W-CW){mat_rd[CW-1]}}, mat_rd};
      B_SLOT:  b_opnd = slot_rd;
      B_X:     b_opnd = {{(W-32){px_r[31]}}, px_r};
      B_Y:     b_opnd = {{(W-32){py_r[31]}}, py_r};
      B_ONE:   b_opnd = W'(1) << FRAC_BITS;
      default: b_opnd = '0;
    endcase
  end

  assign acc_base = st.first ? '0 : acc_r;
  assign acc_nxt  = st.sub ? (acc_base - prod) : (acc_base + prod);

  assign cv_w = {{(W-32){in_coeff_value[31]}}, in_coeff_value};
  always_comb begin
    if ((&cv_w[W-1:CW-1]) || !(|cv_w[W-1:CW-1])) cv_sat = cv_w[CW-1:0];
    else cv_sat = cv_w[W-1] ? C_MIN : C_MAX;
  end

  always_comb begin
    q_cw_sat = !((&quo[W-1:CW-1]) || !(|quo[W-1:CW-1]));
    q_cw     = q_cw_sat ? (quo[W-1] ? C_MIN : C_MAX) : quo[CW-1:0];
    q_32_sat = !((&quo[W-1:31]) || !(|quo[W-1:31]));
    q_32     = q_32_sat ? (quo[W-1] ? P_MIN : P_MAX) : quo[31:0];
  end

  ppt_mul #(.AW(CW), .W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(opa_r), .b(b_opnd),
    .done(mul_done), .prod(prod)
  );

  ppt_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(dividend), .den(den),
    .done(div_done), .quo(quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_INVERT || in_opcode == OP_XFORM) state_nxt = ST_OPA;
          else state_nxt = ST_OUT;
        end
      end
      ST_OPA:  state_nxt = ST_OPB;
      ST_OPB:  state_nxt = ST_MULW;
      ST_MULW: begin
        if (mul_done) begin
          if (step_r == (is_inv ? INV_LAST_STEP : XF_LAST_STEP)) state_nxt = ST_CHECK;
          else state_nxt = ST_OPA;
        end
      end
      ST_CHECK: state_nxt = den_zero ? ST_OUT : ST_DIVS;
      ST_DIVS:  state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          if (k_r == (is_inv ? INV_LAST_DIV : XF_LAST_DIV)) state_nxt = ST_OUT;
          else state_nxt = ST_DIVS;
        end
      end
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_OPB:  mul_start = 1'b1;
      ST_DIVS: div_start = 1'b1;
      ST_OUT:  out_load  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) mat_r[i] <= (i % 4 == 0) ? ONE_C : '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r    <= in_opcode;
            px_r    <= in_point_x;
            py_r    <= in_point_y;
            step_r  <= '0;
            k_r     <= '0;
            sat_r   <= 1'b0;
            rx_r    <= '0;
            ry_r    <= '0;
            rstat_r <= STAT_OK;
            if (in_opcode == OP_WRITE && in_coeff_index < NUM_COEFF)
              mat_r[in_coeff_index] <= cv_sat;
          end
        end
        ST_OPA: opa_r <= mat_rd;
        ST_MULW: begin
          if (mul_done) begin
            acc_r  <= acc_nxt;
            step_r <= step_r + 5'd1;
            if (st.last) slot_r[st.dst] <= acc_nxt;
          end
        end
        ST_CHECK: begin
          if (den_zero) begin
            if (is_inv) begin
              for (int i = 0; i < 9; i++) mat_r[i] <= (i % 4 == 0) ? ONE_C : '0;
              rstat_r <= STAT_SINGULAR;
            end else begin
              rstat_r <= STAT_SAT;
              rx_r <= (slot_r[0] == '0) ? 32'sd0 : (slot_r[0][W-1] ? P_MIN : P_MAX);
              ry_r <= (slot_r[1] == '0) ? 32'sd0 : (slot_r[1][W-1] ? P_MIN : P_MAX);
            end
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            k_r <= k_r + 4'd1;
            if (is_inv) begin
              mat_r[k_r] <= q_cw;
              if (q_cw_sat || sat_r) rstat_r <= STAT_SAT;
              sat_r <= sat_r | q_cw_sat;
            end else begin
              if (k_r == 4'd0) rx_r <= q_32;
              else ry_r <= q_32;
              if (q_32_sat || sat_r) rstat_r <= STAT_SAT;
              sat_r <= sat_r | q_32_sat;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_x_r      <= rx_r;
            out_y_r      <= ry_r;
            out_status_r <= rstat_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_status = out_status_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("item accepted but block stayed idle");
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !den_zero)
    else $error("divide started with zero denominator");
  a_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MULW)
    else $error("multiply result with no waiting step");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIVW)
    else $error("divide result with no waiting step");
endmodule
